FILE: sv/nnfs_pkg.sv
`default_nettype none
package nnfs_pkg;

  localparam int STORE_DEPTH   = 16384;
  localparam int STORE_ADDR_W  = $clog2(STORE_DEPTH);
  localparam int MAX_DST_WIDTH = 160;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  // The queue pointers wrap by overflow, so the depth stays a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Dividend is destination coordinate (8 bits) times source size (9 bits).
  localparam int DIVIDEND_W = 17;
  localparam int DIVISOR_W  = 8;
  localparam int QUOT_W     = 9;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Source address is source row times source width plus source column.
  localparam int SRC_ADDR_W = 19;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_MEM,
    ST_WB
  } back_state_t;

  typedef struct packed {
    logic        func;
    logic [15:0] load_index;
    logic [15:0] load_pixel;
  } in_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic        row_last;
    logic        frame_last;
  } out_t;

  typedef struct packed {
    logic [8:0] src_width;
    logic [8:0] src_height;
    logic [7:0] dst_width;
    logic [7:0] dst_height;
  } cfg_t;

  typedef struct packed {
    op_t                     op;
    logic [STORE_ADDR_W-1:0] addr;
    logic [15:0]             pixel;
  } qent_t;

endpackage
`default_nettype wire

FILE: sv/nearest_neighbor_frame_scaler_top.sv
// Load words: taken at one per cycle while the queue has room; the pixel is
// written to the frame store in the cycle after acceptance when the queue is empty
// and the back end is idle. A read passes the MUL, DIV (17-step serial dividers),
// ADDR and MEM states and is registered in WB; the next word waits until it is out.
// Reset clears the queue, the cursor and the output valid, and sets all four size
// registers to 128. The frame store is not cleared and holds garbage until loaded.
`default_nettype none
module nearest_neighbor_frame_scaler_top
  import nnfs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_t                    in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_t                        out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  qent_t q_head;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= 9'd128;
      cfg.src_height <= 9'd128;
      cfg.dst_width  <= 8'd128;
      cfg.dst_height <= 8'd128;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data;
        REG_SRC_HEIGHT: cfg.src_height <= cfg_data;
        REG_DST_WIDTH:  cfg.dst_width  <= cfg_data[7:0];
        REG_DST_HEIGHT: cfg.dst_height <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  nnfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  nnfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_frame_last_ends_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.frame_last || out_data.row_last))
    else $error("frame_last without row_last");

  a_col_in_buffer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.out_col < 8'(MAX_DST_WIDTH)))
    else $error("output column beyond row buffer");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

FILE: sv/nnfs_div.sv
`default_nettype none
module nnfs_div
  import nnfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic [QUOT_W-1:0]          quotient
);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Restoring division, one quotient bit per cycle. The remainder always
  // stays below the divisor, so it fits in the divisor's width.
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  // The scaled coordinate stays below the source size, or is zero when that size is zero.
  assign quotient = quo[QUOT_W-1:0];

endmodule
`default_nettype wire

FILE: sv/nnfs_front.sv
`default_nettype none
module nnfs_front
  import nnfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire in_t   in_data,
  output logic       q_valid,
  output qent_t      q_head,
  input  wire logic  q_pop
);

  qent_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   full;
  logic                   in_range;
  logic                   push;
  qent_t                  ent;

  assign full     = count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign in_ready = !full;
  assign q_valid  = count != '0;
  assign q_head   = entries[rd_ptr];

  // Loads that fall outside the store are taken and dropped here.
  assign in_range = {1'b0, in_data.load_index} < 17'(STORE_DEPTH);
  assign push     = in_valid && in_ready &&
                    (op_t'(in_data.func) == OP_READ || in_range);

  always_comb begin
    ent.op    = op_t'(in_data.func);
    ent.addr  = in_data.load_index[STORE_ADDR_W-1:0];
    ent.pixel = in_data.load_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= ent;
    end
  end

endmodule
`default_nettype wire

FILE: sv/nnfs_back.sv
`default_nettype none
module nnfs_back
  import nnfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  input  wire qent_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_t       out_data
);

  back_state_t state, state_next;

  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rd_data;

  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic [7:0] w_eff;
  logic [7:0] h_eff;
  logic [7:0] col_sel;
  logic [7:0] row_sel;
  logic       rl_sel;
  logic       fl_sel;

  logic [7:0] col_r;
  logic [7:0] row_r;
  logic       rl_r;
  logic       fl_r;
  logic [SRC_ADDR_W-1:0] addr_r;
  logic       oor_r;

  logic       div_start;
  logic       div_x_busy;
  logic       div_y_busy;
  logic [QUOT_W-1:0] sx;
  logic [QUOT_W-1:0] sy;
  logic [DIVIDEND_W-1:0] prod_x;
  logic [DIVIDEND_W-1:0] prod_y;

  logic       mem_we;
  logic       mem_re;
  logic       load_out;
  logic       take_read;

  // Zero sizes act as one, and the width is capped at the row buffer size.
  always_comb begin
    if (cfg.dst_width == '0) begin
      w_eff = 8'd1;
    end else if (cfg.dst_width > 8'(MAX_DST_WIDTH)) begin
      w_eff = 8'(MAX_DST_WIDTH);
    end else begin
      w_eff = cfg.dst_width;
    end
    h_eff = (cfg.dst_height == '0) ? 8'd1 : cfg.dst_height;
  end

  // A cursor left stale by a size change restarts at zero.
  assign col_sel = (cursor_col < w_eff) ? cursor_col : 8'd0;
  assign row_sel = (cursor_row < h_eff) ? cursor_row : 8'd0;
  assign rl_sel  = col_sel == (w_eff - 8'd1);
  assign fl_sel  = rl_sel && (row_sel == (h_eff - 8'd1));

  assign prod_x = DIVIDEND_W'(col_r) * DIVIDEND_W'(cfg.src_width);
  assign prod_y = DIVIDEND_W'(row_r) * DIVIDEND_W'(cfg.src_height);

  nnfs_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_x),
    .divisor  (w_eff),
    .busy     (div_x_busy),
    .quotient (sx)
  );

  nnfs_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_y),
    .divisor  (h_eff),
    .busy     (div_y_busy),
    .quotient (sy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.op == OP_READ) begin
            state_next = ST_MUL;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_MUL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!div_x_busy && !div_y_busy) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_next = ST_MEM;
      end
      ST_MEM: begin
        mem_re     = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign take_read = q_pop && (q_head.op == OP_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (take_read) begin
      if (fl_sel) begin
        cursor_col <= '0;
        cursor_row <= '0;
      end else if (rl_sel) begin
        cursor_col <= '0;
        cursor_row <= row_sel + 8'd1;
      end else begin
        cursor_col <= col_sel + 8'd1;
        cursor_row <= row_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_read) begin
      col_r <= col_sel;
      row_r <= row_sel;
      rl_r  <= rl_sel;
      fl_r  <= fl_sel;
    end
    if (state == ST_ADDR) begin
      addr_r <= SRC_ADDR_W'(sy) * SRC_ADDR_W'(cfg.src_width) + SRC_ADDR_W'(sx);
    end
    if (mem_re) begin
      oor_r <= addr_r >= SRC_ADDR_W'(STORE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.addr] <= q_head.pixel;
    end
    if (mem_re) begin
      rd_data <= mem[addr_r[STORE_ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.pixel      <= oor_r ? 16'd0 : rd_data;
      out_data.out_col    <= col_r;
      out_data.out_row    <= row_r;
      out_data.row_last   <= rl_r;
      out_data.frame_last <= fl_r;
    end
  end

endmodule
`default_nettype wire

FILE: tb/nearest_neighbor_frame_scaler_top_test.sv
`timescale 1ns / 1ps
module nearest_neighbor_frame_scaler_top_test;
  import nnfs_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int SETTLE_TICKS = 30;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic [1:0] {
    ROW_CONFIG,
    ROW_WORD,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_t      sizes;
    in_t       w;
    out_t      res;
  } stim_row_t;

  typedef struct {
    cfg_t       sizes;
    idle_mode_t mode;
    int         n_words;
    int         read_pct;
    bit         long_hold;
  } phase_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predictor state: the stored source frame, the destination cursor and the sizes.
  logic [15:0] src_frame [STORE_DEPTH];
  bit          src_loaded [STORE_DEPTH];
  logic [7:0]  dst_col = '0;
  logic [7:0]  dst_row = '0;
  cfg_t        sizes_now = '{9'd128, 9'd128, 8'd128, 8'd128};

  out_t       pending_pixels [$];
  idle_mode_t tx_mode = IDLE_NONE;
  idle_mode_t rx_mode = IDLE_NONE;
  int         hold_req = 0;
  int         hold_ack = 0;
  int         hold_left = 0;
  int         errors = 0;
  int         loads_sent = 0;
  int         reads_sent = 0;
  int         pixels_checked = 0;
  int         frames_done = 0;

  nearest_neighbor_frame_scaler_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_pct(idle_mode_t m, bit sender_side);
    case (m)
      IDLE_BOTH:     return 20;
      IDLE_SENDER:   return sender_side ? 67 : 0;
      IDLE_RECEIVER: return sender_side ? 0 : 67;
      default:       return 0;
    endcase
  endfunction

  // Where the next read lands: effective sizes, cursor and source address.
  function automatic void cursor_lookup(output int col, output int row, output int wd,
                                        output int ht, output int addr);
    wd = (sizes_now.dst_width == 0) ? 1 : int'(sizes_now.dst_width);
    if (wd > MAX_DST_WIDTH) wd = MAX_DST_WIDTH;
    ht = (sizes_now.dst_height == 0) ? 1 : int'(sizes_now.dst_height);
    col = (int'(dst_col) < wd) ? int'(dst_col) : 0;
    row = (int'(dst_row) < ht) ? int'(dst_row) : 0;
    addr = (row * int'(sizes_now.src_height) / ht) * int'(sizes_now.src_width)
         + col * int'(sizes_now.src_width) / wd;
  endfunction

  function automatic bit scale_next(input in_t w, output out_t res);
    int col, row, wd, ht, addr;
    res = '0;
    if (w.func == OP_LOAD) begin
      if (w.load_index < STORE_DEPTH) begin
        src_frame[w.load_index]  = w.load_pixel;
        src_loaded[w.load_index] = 1'b1;
      end
      return 1'b0;
    end
    cursor_lookup(col, row, wd, ht, addr);
    res.pixel      = (addr < STORE_DEPTH) ? src_frame[addr] : 16'h0000;
    res.out_col    = 8'(col);
    res.out_row    = 8'(row);
    res.row_last   = (col == wd - 1);
    res.frame_last = res.row_last && (row == ht - 1);
    if (res.frame_last) begin
      dst_col = '0;
      dst_row = '0;
    end else if (res.row_last) begin
      dst_col = '0;
      dst_row = 8'(row + 1);
    end else begin
      dst_col = 8'(col + 1);
      dst_row = 8'(row);
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t cfg_row(int sw, int sh, int dw, int dh);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_CONFIG;
    r.sizes = '{9'(sw), 9'(sh), 8'(dw), 8'(dh)};
    return r;
  endfunction

  function automatic stim_row_t load_row(int idx, int pix);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.w    = '{OP_LOAD, 16'(idx), 16'(pix)};
    return r;
  endfunction

  function automatic stim_row_t read_row();
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.w    = '{OP_READ, 16'h0000, 16'h0000};
    return r;
  endfunction

  function automatic stim_row_t checked_row(int pix, int col, int row, bit rl, bit fl);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CHECKED;
    r.w    = '{OP_READ, 16'hFFFF, 16'hFFFF};
    r.res  = '{16'(pix), 8'(col), 8'(row), rl, fl};
    return r;
  endfunction

  task automatic send_word(input in_t w, input bit typed, input out_t typed_res);
    int   gap;
    out_t res;
    gap = 0;
    while ($urandom_range(99) < idle_pct(tx_mode, 1'b1)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (scale_next(w, res)) begin
      pending_pixels.push_back(typed ? typed_res : res);
      reads_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  // Sizes only change with the pipeline empty; loads give no result, so wait
  // out the queued loads as well.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    logic spare;
    cfg_we    <= 1'b1;
    cfg_index <= REG_SRC_WIDTH;
    cfg_data  <= c.src_width;
    @(posedge clk);
    cfg_index <= REG_SRC_HEIGHT;
    cfg_data  <= c.src_height;
    @(posedge clk);
    spare = 1'($urandom_range(1));
    cfg_index <= REG_DST_WIDTH;
    cfg_data  <= {spare, c.dst_width};
    @(posedge clk);
    spare = 1'($urandom_range(1));
    cfg_index <= REG_DST_HEIGHT;
    cfg_data  <= {spare, c.dst_height};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sizes_now = c;
  endtask

  // Reads whose source pixel was never loaded are turned into the missing load.
  task automatic random_word(input int read_pct);
    in_t w;
    int  col, row, wd, ht, addr, span, r;
    w.func       = OP_LOAD;
    w.load_index = 16'($urandom);
    w.load_pixel = 16'($urandom);
    r = $urandom_range(99);
    if (r < read_pct) begin
      cursor_lookup(col, row, wd, ht, addr);
      if (addr >= STORE_DEPTH || src_loaded[addr]) w.func = OP_READ;
      else w.load_index = 16'(addr);
    end else if (r < read_pct + (100 - read_pct) * 3 / 4) begin
      span = int'(sizes_now.src_width) * int'(sizes_now.src_height);
      if (span > STORE_DEPTH) span = STORE_DEPTH;
      if (span < 1) span = 1;
      w.load_index = 16'($urandom_range(span - 1));
    end
    send_word(w, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct(rx_mode, 1'b0));
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result word %p", out_data);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel !== want.pixel) begin
          $error("pixel: expected %h, got %h", want.pixel, out_data.pixel);
          errors++;
        end
        if (out_data.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
          errors++;
        end
        if (out_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
          errors++;
        end
        if (out_data.row_last !== want.row_last) begin
          $error("row_last: expected %b, got %b", want.row_last, out_data.row_last);
          errors++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last: expected %b, got %b", want.frame_last, out_data.frame_last);
          errors++;
        end
        if (want.frame_last) frames_done++;
        pixels_checked++;
      end
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    phase_t    phases [$];
    cfg_t      sizes;

    // Defaults first, then out-of-range loads, a stale cursor, zero and
    // oversize sizes, and reads that fall outside the store.
    directed_rows.push_back(load_row(0, 16'hFFFF));
    directed_rows.push_back(load_row(STORE_DEPTH - 1, 16'h0000));
    directed_rows.push_back(load_row(STORE_DEPTH, 16'hA5A5));
    directed_rows.push_back(load_row(16'hFFFF, 16'h5A5A));
    directed_rows.push_back(checked_row(16'hFFFF, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(load_row(1, 16'h1234));
    directed_rows.push_back(checked_row(16'h1234, 1, 0, 1'b0, 1'b0));
    directed_rows.push_back(cfg_row(2, 2, 1, 1));
    directed_rows.push_back(checked_row(16'hFFFF, 0, 0, 1'b1, 1'b1));
    directed_rows.push_back(cfg_row(2, 2, 0, 0));
    directed_rows.push_back(checked_row(16'hFFFF, 0, 0, 1'b1, 1'b1));
    directed_rows.push_back(cfg_row(0, 0, 255, 255));
    directed_rows.push_back(checked_row(16'hFFFF, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'hFFFF, 1, 0, 1'b0, 1'b0));
    directed_rows.push_back(cfg_row(511, 511, 2, 2));
    directed_rows.push_back(load_row(255, 16'h0F0F));
    directed_rows.push_back(checked_row(16'hFFFF, 0, 0, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'h0F0F, 1, 0, 1'b1, 1'b0));
    directed_rows.push_back(checked_row(16'h0000, 0, 1, 1'b0, 1'b0));
    directed_rows.push_back(checked_row(16'h0000, 1, 1, 1'b1, 1'b1));
    directed_rows.push_back(cfg_row(4, 4, 4, 4));
    directed_rows.push_back(read_row());
    directed_rows.push_back(read_row());

    phases.push_back('{'{9'd256, 9'd256, 8'd255, 8'd255}, IDLE_NONE, 120, 55, 1'b0});
    phases.push_back('{'{9'd1, 9'd1, 8'd1, 8'd1}, IDLE_SENDER, 100, 60, 1'b0});
    phases.push_back('{'{9'd8, 9'd8, 8'd4, 8'd4}, IDLE_NONE, 120, 80, 1'b1});
    // One column and the tallest frame, 255 rows, walk the row counter up towards row 254.
    phases.push_back('{'{9'd2, 9'd2, 8'd1, 8'd255}, IDLE_BOTH, 300, 92, 1'b0});
    for (int i = 4; i < 12; i++) begin
      sizes.src_width  = ($urandom_range(5) == 0) ? 9'($urandom_range(511))
                                                  : 9'($urandom_range(1, 12));
      sizes.src_height = ($urandom_range(5) == 0) ? 9'($urandom_range(511))
                                                  : 9'($urandom_range(1, 12));
      sizes.dst_width  = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(1, 6));
      sizes.dst_height = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(1, 6));
      phases.push_back('{sizes, idle_mode_t'(i % 4), 114, 60, 1'b0});
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: begin
          settle_idle();
          apply_config(directed_rows[i].sizes);
        end
        ROW_CHECKED: send_word(directed_rows[i].w, 1'b1, directed_rows[i].res);
        default:     send_word(directed_rows[i].w, 1'b0, '0);
      endcase
    end

    foreach (phases[p]) begin
      settle_idle();
      apply_config(phases[p].sizes);
      tx_mode = phases[p].mode;
      rx_mode = phases[p].mode;
      if (phases[p].long_hold) hold_req++;
      for (int n = 0; n < phases[p].n_words; n++) random_word(phases[p].read_pct);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Sent %0d loads and %0d reads; checked %0d scaled pixels, %0d complete frames.",
             loads_sent, reads_sent, pixels_checked, frames_done);
    $display("Covered %0d size settings with zero, oversize and clamped sizes under four "
             , phases.size() + 5, "idling patterns and one long output stall.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: nearest_neighbor_frame_scaler_top.f
sv/nnfs_pkg.sv
sv/nnfs_div.sv
sv/nnfs_front.sv
sv/nnfs_back.sv
sv/nearest_neighbor_frame_scaler_top.sv
tb/nearest_neighbor_frame_scaler_top_test.sv
